### hdl/mtc_pkg.sv
// Package for the marching-tetrahedra cell core: widths, register indexes and
// the fixed geometry tables. No dependencies.
package mtc_pkg;

  localparam int VALUE_WIDTH_DEF = 16;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int CS_W    = 31;
  localparam int T_W     = 18;
  localparam int NUM_PTS = 19;
  localparam int PT_W    = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [T_W-1:0]  T_ONE = 18'h10000;
  localparam logic [T_W-1:0]  T_TWO = 18'h20000;
  localparam logic [CS_W-1:0] CS_RESET = 31'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_EN   = 8'd2;

  localparam logic [1:0] PT_LOCAL [NUM_PTS][3] = '{
    '{2'd1,2'd0,2'd0}, '{2'd0,2'd1,2'd0}, '{2'd0,2'd0,2'd1}, '{2'd2,2'd1,2'd0},
    '{2'd2,2'd0,2'd1}, '{2'd1,2'd2,2'd0}, '{2'd0,2'd2,2'd1}, '{2'd2,2'd2,2'd1},
    '{2'd1,2'd0,2'd2}, '{2'd0,2'd1,2'd2}, '{2'd2,2'd1,2'd2}, '{2'd1,2'd2,2'd2},
    '{2'd0,2'd1,2'd1}, '{2'd2,2'd1,2'd1}, '{2'd1,2'd0,2'd1}, '{2'd1,2'd2,2'd1},
    '{2'd1,2'd1,2'd0}, '{2'd1,2'd1,2'd2}, '{2'd1,2'd1,2'd1}
  };

  // low nibble start corner, high nibble end corner
  localparam logic [7:0] PT_SEG [NUM_PTS] = '{
    8'h10, 8'h20, 8'h40, 8'h31, 8'h51, 8'h32, 8'h62, 8'h73, 8'h54, 8'h64,
    8'h75, 8'h76, 8'h60, 8'h71, 8'h50, 8'h72, 8'h30, 8'h74, 8'h70
  };

  localparam logic [PT_W-1:0] TET_PTS [6][6] = '{
    '{5'd1, 5'd12, 5'd6,  5'd18, 5'd15, 5'd11},
    '{5'd4, 5'd14, 5'd0,  5'd10, 5'd13, 5'd18},
    '{5'd8, 5'd2,  5'd14, 5'd17, 5'd10, 5'd18},
    '{5'd5, 5'd16, 5'd1,  5'd7,  5'd15, 5'd18},
    '{5'd3, 5'd0,  5'd16, 5'd13, 5'd7,  5'd18},
    '{5'd9, 5'd12, 5'd2,  5'd11, 5'd17, 5'd18}
  };

  localparam logic [2:0] TET_CORNERS [6][4] = '{
    '{3'd0,3'd2,3'd6,3'd7}, '{3'd5,3'd1,3'd0,3'd7}, '{3'd4,3'd5,3'd0,3'd7},
    '{3'd3,3'd2,3'd0,3'd7}, '{3'd1,3'd3,3'd0,3'd7}, '{3'd6,3'd4,3'd0,3'd7}
  };

  // low nibble corner count, nibble at 8+4k point slot of corner k
  localparam logic [31:0] TET_TRIS [16] = '{
    32'h00000000, 32'h00031003, 32'h00024003, 32'h31441206,
    32'h00052103, 32'h35203206, 32'h15054006, 32'h00054303,
    32'h00045303, 32'h51045006, 32'h25053006, 32'h00025103,
    32'h34142106, 32'h00042003, 32'h00013003, 32'h00000000
  };

  function automatic logic [3:0] tet_cfg(input logic [7:0] mask, input logic [2:0] th);
    logic [3:0] c;
    for (int k = 0; k < 4; k++) begin
      c[k] = mask[TET_CORNERS[th][k]];
    end
    return c;
  endfunction

endpackage

### hdl/mtc_if.sv
// Channel interfaces of the marching-tetrahedra cell core: cell input, vertex
// output and register write. Depends on nothing but the widths handed in.
interface mtc_in_if #(parameter int VALUE_WIDTH = 16, parameter int COORD_WIDTH = 32);
  logic                           valid;
  logic                           ready;
  logic [7:0]                     corner_mask;
  logic signed [VALUE_WIDTH-1:0]  corner_value_0;
  logic signed [VALUE_WIDTH-1:0]  corner_value_1;
  logic signed [VALUE_WIDTH-1:0]  corner_value_2;
  logic signed [VALUE_WIDTH-1:0]  corner_value_3;
  logic signed [VALUE_WIDTH-1:0]  corner_value_4;
  logic signed [VALUE_WIDTH-1:0]  corner_value_5;
  logic signed [VALUE_WIDTH-1:0]  corner_value_6;
  logic signed [VALUE_WIDTH-1:0]  corner_value_7;
  logic signed [COORD_WIDTH-1:0]  origin_x;
  logic signed [COORD_WIDTH-1:0]  origin_y;
  logic signed [COORD_WIDTH-1:0]  origin_z;
  modport source (output valid, corner_mask, corner_value_0, corner_value_1, corner_value_2,
                  corner_value_3, corner_value_4, corner_value_5, corner_value_6,
                  corner_value_7, origin_x, origin_y, origin_z, input ready);
  modport sink (input valid, corner_mask, corner_value_0, corner_value_1, corner_value_2,
                corner_value_3, corner_value_4, corner_value_5, corner_value_6,
                corner_value_7, origin_x, origin_y, origin_z, output ready);
endinterface

interface mtc_out_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic [4:0]                    vertex_index;
  logic                          first_use;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic                          last_corner;
  modport source (output valid, vertex_index, first_use, pos_x, pos_y, pos_z, last_corner,
                  input ready);
  modport sink (input valid, vertex_index, first_use, pos_x, pos_y, pos_z, last_corner,
                output ready);
endinterface

interface mtc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/mtc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### hdl/marching_tetrahedra_cell_core.sv
// Top level of the marching-tetrahedra cell core.
// Depends on mtc_pkg, the channel interfaces in mtc_if.sv and mtc_ram.
//
// One cube cell is taken per input beat; the block then walks the six
// tetrahedra and sends one output beat per triangle corner (0 to 36 per cell,
// none for an all-inside or all-outside mask). Each corner passes through
// an issue step, a vertex-table read, an 18-step restoring divider for t,
// one multiply by cell_size and a saturating add; corners whose t is fixed
// skip the divider. Stepping past each tetrahedron that has no corners left
// takes an extra pass through the issue step. A stalled output holds the
// add stage. A cell with no corners frees the input at once. The vertex
// numbering lives in a 19-entry RAM with per-cell valid flags. The next
// cell is taken as soon as the last corner sits in the output register.
module marching_tetrahedra_cell_core #(
  parameter int VALUE_WIDTH = mtc_pkg::VALUE_WIDTH_DEF,
  parameter int COORD_WIDTH = mtc_pkg::COORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mtc_in_if.sink    in_ch,
  mtc_out_if.source out_ch,
  mtc_cfg_if.sink   cfg_ch
);
  import mtc_pkg::*;

  localparam int DW = VALUE_WIDTH + 1;
  localparam int RW = VALUE_WIDTH + 2;
  localparam int SW = (COORD_WIDTH > 32 ? COORD_WIDTH : 32) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;

  logic signed [VALUE_WIDTH-1:0] thr_r;
  logic [CS_W-1:0]               cs_r;
  logic                          ie_r;

  logic [7:0]                    mask_r;
  logic signed [VALUE_WIDTH-1:0] val_r [8];
  logic signed [COORD_WIDTH-1:0] org_r [3];

  logic [2:0]       state_r, state_nxt;
  logic [2:0]       tet_r, tet_nxt;
  logic [2:0]       k_r, k_nxt;
  logic [5:0]       total_r, total_nxt;
  logic [5:0]       done_r, done_nxt;
  logic [4:0]       nverts_r, nverts_nxt;
  logic [NUM_PTS-1:0] vld_r, vld_nxt;
  logic [PT_W-1:0]  pt_r, pt_nxt;
  logic [4:0]       vidx_r, vidx_nxt;
  logic             first_r, first_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    ud_r, ud_nxt;
  logic [T_W-1:0]   q_r, q_nxt;
  logic [4:0]       dcnt_r, dcnt_nxt;
  logic [T_W-1:0]   t_r, t_nxt;
  logic [31:0]      offm_r, offm_nxt;

  logic                          ov_r, ov_nxt;
  logic [4:0]                    o_vidx_r, o_vidx_nxt;
  logic                          o_first_r, o_first_nxt;
  logic signed [COORD_WIDTH-1:0] o_pos_r [3];
  logic signed [COORD_WIDTH-1:0] o_pos_nxt [3];
  logic                          o_last_r, o_last_nxt;

  logic            ram_we, ram_re;
  logic [PT_W-1:0] ram_waddr, ram_raddr;
  logic [4:0]      ram_wdata, ram_rdata;

  mtc_ram #(.WIDTH(5), .DEPTH(NUM_PTS)) u_vtab (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = ov_r;
  assign out_ch.vertex_index = o_vidx_r;
  assign out_ch.first_use    = o_first_r;
  assign out_ch.pos_x        = o_pos_r[0];
  assign out_ch.pos_y        = o_pos_r[1];
  assign out_ch.pos_z        = o_pos_r[2];
  assign out_ch.last_corner  = o_last_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      cs_r  <= CS_RESET;
      ie_r  <= 1'b1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_THRESHOLD: thr_r <= cfg_ch.data[VALUE_WIDTH-1:0];
        REG_CELL_SIZE: cs_r  <= cfg_ch.data[CS_W-1:0];
        REG_INTERP_EN: ie_r  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // cell payload capture
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      mask_r   <= in_ch.corner_mask;
      val_r[0] <= in_ch.corner_value_0;
      val_r[1] <= in_ch.corner_value_1;
      val_r[2] <= in_ch.corner_value_2;
      val_r[3] <= in_ch.corner_value_3;
      val_r[4] <= in_ch.corner_value_4;
      val_r[5] <= in_ch.corner_value_5;
      val_r[6] <= in_ch.corner_value_6;
      val_r[7] <= in_ch.corner_value_7;
      org_r[0] <= in_ch.origin_x;
      org_r[1] <= in_ch.origin_y;
      org_r[2] <= in_ch.origin_z;
    end
  end

  always_comb begin
    logic [31:0]             tri_w;
    logic [3:0]              slot;
    logic [2:0]              slot6;
    logic [PT_W-1:0]         p;
    logic [5:0]              sum_cnt;
    logic signed [DW-1:0]    a, b, num, den;
    logic [DW-1:0]           un, ud;
    logic [RW-1:0]           rem_sh;
    logic [T_W-1:0]          qv;
    logic [CS_W+T_W-1:0]     prod;
    logic [31:0]             off;
    logic signed [SW-1:0]    s;
    logic [1:0]              c;

    state_nxt = state_r;
    tet_nxt = tet_r;
    k_nxt = k_r;
    total_nxt = total_r;
    done_nxt = done_r;
    nverts_nxt = nverts_r;
    vld_nxt = vld_r;
    pt_nxt = pt_r;
    vidx_nxt = vidx_r;
    first_nxt = first_r;
    rem_nxt = rem_r;
    ud_nxt = ud_r;
    q_nxt = q_r;
    dcnt_nxt = dcnt_r;
    t_nxt = t_r;
    offm_nxt = offm_r;
    ov_nxt = ov_r && !out_ch.ready;
    o_vidx_nxt = o_vidx_r;
    o_first_nxt = o_first_r;
    o_pos_nxt = o_pos_r;
    o_last_nxt = o_last_r;
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_waddr = pt_r;
    ram_wdata = nverts_r;
    off = '0;
    s = '0;
    c = '0;

    tri_w = TET_TRIS[tet_cfg(mask_r, tet_r)];
    slot  = tri_w[8 + 4 * k_r +: 4];
    slot6 = (slot >= 4'd6) ? 3'(slot - 4'd6) : slot[2:0];
    p     = TET_PTS[tet_r][slot6];
    ram_raddr = p;

    a   = DW'(val_r[PT_SEG[pt_r][2:0]]);
    b   = DW'(val_r[PT_SEG[pt_r][6:4]]);
    num = DW'(thr_r) - a;
    den = b - a;
    un  = num[DW-1] ? DW'(-num) : DW'(num);
    ud  = den[DW-1] ? DW'(-den) : DW'(den);

    rem_sh = (rem_r >= RW'(ud_r)) ? (rem_r - RW'(ud_r)) : rem_r;
    qv     = {q_r[T_W-2:0], (rem_r >= RW'(ud_r))};

    prod = (CS_W+T_W)'(t_r) * (CS_W+T_W)'(cs_r);

    sum_cnt = '0;
    for (int th = 0; th < 6; th++) begin
      sum_cnt = sum_cnt + 6'(TET_TRIS[tet_cfg(in_ch.corner_mask, 3'(th))][3:0]);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          total_nxt = sum_cnt;
          done_nxt = '0;
          nverts_nxt = '0;
          vld_nxt = '0;
          tet_nxt = '0;
          k_nxt = '0;
          state_nxt = (sum_cnt == '0) ? S_IDLE : S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (4'(k_r) < tri_w[3:0]) begin
          ram_re = 1'b1;
          pt_nxt = p;
          state_nxt = S_LOOK;
        end else begin
          tet_nxt = tet_r + 3'd1;
          k_nxt = '0;
        end
      end
      S_LOOK: begin
        if (vld_r[pt_r]) begin
          vidx_nxt = ram_rdata;
          first_nxt = 1'b0;
        end else begin
          vidx_nxt = nverts_r;
          first_nxt = 1'b1;
          ram_we = 1'b1;
          vld_nxt[pt_r] = 1'b1;
          nverts_nxt = nverts_r + 5'd1;
        end
        state_nxt = S_MUL;
        if (!ie_r || den == '0) begin
          t_nxt = T_ONE;
        end else if ((num[DW-1] != den[DW-1]) || un == '0) begin
          t_nxt = '0;
        end else if (RW'(un) >= {1'b0, ud, 1'b0} >> 1 << 1 && RW'(un) >= (RW'(ud) << 1)) begin
          t_nxt = T_TWO;
        end else begin
          rem_nxt = RW'(un);
          ud_nxt = ud;
          q_nxt = '0;
          dcnt_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        q_nxt = qv;
        rem_nxt = rem_sh << 1;
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'(T_W - 1)) begin
          t_nxt = (qv > T_TWO) ? T_TWO : qv;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        offm_nxt = prod[CS_W+T_W-1 -: 32];
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          o_vidx_nxt = vidx_r;
          o_first_nxt = first_r;
          o_last_nxt = (done_r + 6'd1 == total_r);
          for (int ax = 0; ax < 3; ax++) begin
            c = PT_LOCAL[pt_r][ax];
            off = (c == 2'd0) ? '0 : (c == 2'd2) ? 32'(cs_r) : offm_r;
            s = SW'(org_r[ax]) + SW'(off);
            if (s[SW-1:COORD_WIDTH-1] != {(SW-COORD_WIDTH+1){s[SW-1]}}) begin
              o_pos_nxt[ax] = s[SW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                      : {1'b0, {(COORD_WIDTH-1){1'b1}}};
            end else begin
              o_pos_nxt[ax] = s[COORD_WIDTH-1:0];
            end
          end
          done_nxt = done_r + 6'd1;
          k_nxt = k_r + 3'd1;
          state_nxt = (done_r + 6'd1 == total_r) ? S_IDLE : S_ISSUE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      vld_r   <= '0;
      tet_r   <= '0;
      k_r     <= '0;
      total_r <= '0;
      done_r  <= '0;
      nverts_r <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      vld_r   <= vld_nxt;
      tet_r   <= tet_nxt;
      k_r     <= k_nxt;
      total_r <= total_nxt;
      done_r  <= done_nxt;
      nverts_r <= nverts_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pt_r      <= pt_nxt;
    vidx_r    <= vidx_nxt;
    first_r   <= first_nxt;
    rem_r     <= rem_nxt;
    ud_r      <= ud_nxt;
    q_r       <= q_nxt;
    t_r       <= t_nxt;
    offm_r    <= offm_nxt;
    o_vidx_r  <= o_vidx_nxt;
    o_first_r <= o_first_nxt;
    o_pos_r   <= o_pos_nxt;
    o_last_r  <= o_last_nxt;
  end

endmodule

### tb/marching_tetrahedra_cell_core_tb.sv
// Testbench for marching_tetrahedra_cell_core: drives cells and register writes,
// predicts every vertex beat from its own model and compares them in order.
// Depends on mtc_pkg, mtc_if.sv and the core.
module marching_tetrahedra_cell_core_tb;
  import mtc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]         mask;
    logic signed [15:0] v7, v6, v5, v4, v3, v2, v1, v0;
    logic signed [31:0] ox, oy, oz;
  } cell_t;

  typedef struct packed {
    logic [4:0]         idx;
    logic               first;
    logic signed [31:0] px, py, pz;
    logic               last;
  } vert_t;

  localparam int LIMIT = 2_000_000;

  logic clk = 0;
  logic rst_n = 0;
  mtc_in_if  #(16, 32) in_ch();
  mtc_out_if #(32)     out_ch();
  mtc_cfg_if           cfg_ch();

  marching_tetrahedra_cell_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  cell_t cell_q[$];
  vert_t vert_q[$];
  int    errors = 0;
  int    cycles = 0;
  logic signed [15:0] iso_level = 0;
  logic [30:0]        cube_len = CS_RESET;
  logic               interp_on = 1;
  int    in_gap = 0, out_gap = 0;
  bit    driving = 0;
  logic  in_acc = 0;

  function automatic int rand_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [17:0] edge_frac(longint a, longint b, longint thr);
    longint num, den;
    longint unsigned un, ud, q;
    num = thr - a;
    den = b - a;
    if (den == 0) return T_ONE;
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = (un << 17) / ud;
    if (((num < 0) != (den < 0)) || q == 0) return '0;
    return q > T_TWO ? T_TWO : q[17:0];
  endfunction

  function automatic logic signed [31:0] offset_pos(longint org, longint unsigned loc);
    longint s;
    s = org + longint'((loc * cube_len) >> 17);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  task automatic predict_vertices(cell_t c);
    longint vals[8];
    longint org[3];
    int     slot_of[NUM_PTS];
    int     nv, cnt, p, prev;
    logic [3:0]  cfg;
    logic [31:0] tris;
    logic [17:0] t;
    longint unsigned loc[3];
    vert_t  v;
    vals = '{c.v0, c.v1, c.v2, c.v3, c.v4, c.v5, c.v6, c.v7};
    org = '{c.ox, c.oy, c.oz};
    foreach (slot_of[i]) slot_of[i] = -1;
    nv = 0;
    prev = vert_q.size();
    for (int th = 0; th < 6; th++) begin
      for (int k = 0; k < 4; k++) cfg[k] = c.mask[TET_CORNERS[th][k]];
      tris = TET_TRIS[cfg];
      cnt = tris[3:0];
      for (int k = 0; k < cnt; k++) begin
        p = TET_PTS[th][(tris >> (8 + 4 * k)) & 15];
        t = T_ONE;
        if (interp_on)
          t = edge_frac(vals[PT_SEG[p][2:0]], vals[PT_SEG[p][6:4]], iso_level);
        v.first = slot_of[p] < 0;
        if (slot_of[p] < 0) slot_of[p] = nv++;
        v.idx = 5'(slot_of[p]);
        for (int a = 0; a < 3; a++)
          loc[a] = PT_LOCAL[p][a] == 1 ? longint'(t) : PT_LOCAL[p][a] * 65536;
        v.px = offset_pos(org[0], loc[0]);
        v.py = offset_pos(org[1], loc[1]);
        v.pz = offset_pos(org[2], loc[2]);
        v.last = 0;
        vert_q.push_back(v);
      end
    end
    if (vert_q.size() > prev) vert_q[$].last = 1;
  endtask

  always @(posedge clk) begin
    in_acc <= in_ch.valid && in_ch.ready;
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
    end else if (in_ch.valid && !in_acc) begin
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_ch.valid <= 0;
    end else if (driving && cell_q.size() > 0) begin
      in_ch.valid <= 1;
      {in_ch.corner_mask, in_ch.corner_value_7, in_ch.corner_value_6, in_ch.corner_value_5,
       in_ch.corner_value_4, in_ch.corner_value_3, in_ch.corner_value_2,
       in_ch.corner_value_1, in_ch.corner_value_0, in_ch.origin_x, in_ch.origin_y,
       in_ch.origin_z} <= cell_q.pop_front();
      in_gap <= rand_gap();
    end else begin
      in_ch.valid <= 0;
    end
  end

  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= 1;
      if (out_ch.ready && out_ch.valid) out_gap <= rand_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    vert_t got, want;
    cell_t c;
    cycles <= cycles + 1;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      c = {in_ch.corner_mask, in_ch.corner_value_7, in_ch.corner_value_6,
           in_ch.corner_value_5, in_ch.corner_value_4, in_ch.corner_value_3,
           in_ch.corner_value_2, in_ch.corner_value_1, in_ch.corner_value_0,
           in_ch.origin_x, in_ch.origin_y, in_ch.origin_z};
      predict_vertices(c);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.vertex_index, out_ch.first_use, out_ch.pos_x, out_ch.pos_y,
             out_ch.pos_z, out_ch.last_corner};
      if (vert_q.size() == 0) begin
        $error("unexpected vertex beat %h", got);
        errors++;
      end else begin
        want = vert_q.pop_front();
        if (got.idx !== want.idx) begin
          $error("vertex_index exp %0d got %0d", want.idx, got.idx); errors++;
        end
        if (got.first !== want.first) begin
          $error("first_use exp %0d got %0d", want.first, got.first); errors++;
        end
        if (got.px !== want.px) begin
          $error("pos_x exp %h got %h", want.px, got.px); errors++;
        end
        if (got.py !== want.py) begin
          $error("pos_y exp %h got %h", want.py, got.py); errors++;
        end
        if (got.pz !== want.pz) begin
          $error("pos_z exp %h got %h", want.pz, got.pz); errors++;
        end
        if (got.last !== want.last) begin
          $error("last_corner exp %0d got %0d", want.last, got.last); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_THRESHOLD) iso_level = data[15:0];
    else if (idx == REG_CELL_SIZE) cube_len = data[30:0];
    else if (idx == REG_INTERP_EN) interp_on = data[0];
    @(negedge clk);
    cfg_ch.valid <= 0;
  endtask

  function automatic logic signed [15:0] rand_value(int mode);
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3, 4: return 16'($urandom());
      default: return $signed(16'($urandom_range(0, 1024))) - 16'sd512;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_origin();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff - $urandom_range(0, 200000);
      1: return 32'sh80000000 + $urandom_range(0, 200000);
      2: return $urandom();
      default: return $signed(32'($urandom_range(0, 4000000))) - 32'sd2000000;
    endcase
  endfunction

  function automatic cell_t rand_cell(logic [7:0] mask);
    cell_t c;
    c.mask = mask;
    c.v0 = rand_value(0); c.v1 = rand_value(0); c.v2 = rand_value(0);
    c.v3 = rand_value(0); c.v4 = rand_value(0); c.v5 = rand_value(0);
    c.v6 = rand_value(0); c.v7 = rand_value(0);
    c.ox = rand_origin(); c.oy = rand_origin(); c.oz = rand_origin();
    return c;
  endfunction

  task automatic run_phase(int n_items);
    driving = 1;
    wait (cell_q.size() == 0 && !in_ch.valid && vert_q.size() == 0);
    driving = 0;
    repeat (60) @(posedge clk);
  endtask

  initial begin
    cell_t c;
    in_ch.valid = 0;
    {in_ch.corner_mask, in_ch.corner_value_0, in_ch.corner_value_1, in_ch.corner_value_2,
     in_ch.corner_value_3, in_ch.corner_value_4, in_ch.corner_value_5, in_ch.corner_value_6,
     in_ch.corner_value_7, in_ch.origin_x, in_ch.origin_y, in_ch.origin_z} = '0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = 0;
    cfg_ch.data = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: empty masks, single corners, extreme values and origins
    c = rand_cell(8'h00); cell_q.push_back(c);
    c = rand_cell(8'hff); cell_q.push_back(c);
    for (int i = 0; i < 8; i++) begin
      c = rand_cell(8'(1 << i)); cell_q.push_back(c);
    end
    c = rand_cell(8'h5a);
    {c.v0, c.v1, c.v2, c.v3, c.v4, c.v5, c.v6, c.v7} = '0;
    cell_q.push_back(c);
    c = rand_cell(8'h0f);
    c.v0 = 16'sh8000; c.v1 = 16'sh7fff; c.v2 = 16'sh7fff; c.v3 = 16'sh8000;
    c.v4 = 16'sh7fff; c.v5 = 16'sh8000; c.v6 = 16'sh8000; c.v7 = 16'sh7fff;
    c.ox = 32'sh7fffffff; c.oy = 32'sh80000000; c.oz = 32'sh7fff0000;
    cell_q.push_back(c);
    c = rand_cell(8'h81);
    c.ox = 32'sh80000000; c.oy = 32'sh7fffffff; c.oz = 0;
    cell_q.push_back(c);
    c = rand_cell(8'h7e); cell_q.push_back(c);
    run_phase(0);

    write_reg(REG_CELL_SIZE, 32'hffff_ffff);
    write_reg(REG_THRESHOLD, 32'h0001_8000);
    for (int i = 0; i < 6; i++) cell_q.push_back(rand_cell(8'($urandom_range(1, 254))));
    run_phase(0);

    write_reg(REG_INTERP_EN, 32'h0000_0002);
    write_reg(8'd9, 32'h1234_5678);
    for (int i = 0; i < 6; i++) cell_q.push_back(rand_cell(8'($urandom_range(0, 255))));
    run_phase(0);

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_THRESHOLD, ph == 0 ? 32'h7fff : ph == 1 ? 32'h0 : $urandom());
      write_reg(REG_CELL_SIZE, ph == 0 ? 32'h0 : ph == 1 ? 32'h10000 : $urandom());
      write_reg(REG_INTERP_EN, ph == 3 ? 32'h0 : 32'h1);
      for (int i = 0; i < 21; i++)
        cell_q.push_back(rand_cell($urandom_range(0, 19) == 0 ?
                                   ($urandom_range(0, 1) ? 8'h00 : 8'hff) :
                                   8'($urandom_range(1, 254))));
      run_phase(0);
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### marching_tetrahedra_cell_core.f
hdl/mtc_pkg.sv
hdl/mtc_if.sv
hdl/mtc_ram.sv
hdl/marching_tetrahedra_cell_core.sv
tb/marching_tetrahedra_cell_core_tb.sv
